@@ sv/rbfi_pkg.sv @@
// shared types, codes and saturating helpers for the rigid body force integrator
// no dependencies
`default_nettype none

package rbfi_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned WIDE_W = 52;   // wide enough for any shifted product or sum
    localparam int unsigned MUL_W  = 33;   // signed operand width of the shared multiplier
    localparam int unsigned PROD_W = 66;
    localparam int unsigned FRAC_W = 16;

    localparam logic signed [WIDE_W-1:0] Q_ONE   = 52'sd65536;
    localparam logic signed [WIDE_W-1:0] MAX_S32 = 52'sd2147483647;
    localparam logic signed [WIDE_W-1:0] MIN_S32 = -52'sd2147483648;

    typedef enum logic [2:0] {
        OP_FORCE       = 3'd0,
        OP_TORQUE      = 3'd1,
        OP_IMPULSE     = 3'd2,
        OP_ANG_IMPULSE = 3'd3,
        OP_TIME_STEP   = 3'd4,
        OP_CLEAR       = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CFG_INVERSE_MASS    = 3'd0,
        CFG_LINEAR_DAMPING  = 3'd1,
        CFG_ANGULAR_DAMPING = 3'd2,
        CFG_IS_DYNAMIC      = 3'd3,
        CFG_FIXED_ROTATION  = 3'd4,
        CFG_AWAKE           = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        LANE_X = 2'd0,
        LANE_Y = 2'd1,
        LANE_A = 2'd2
    } lane_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_KL_MUL,
        ST_KL_WB,
        ST_KA_MUL,
        ST_KA_WB,
        ST_T_MUL,
        ST_T_WB,
        ST_U_MUL,
        ST_U_WB,
        ST_SUM,
        ST_V_MUL,
        ST_V_WB,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } sat_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        if (v > MAX_S32) begin
            r.hit   = 1'b1;
            r.value = 32'h7FFF_FFFF;
        end else if (v < MIN_S32) begin
            r.hit   = 1'b1;
            r.value = 32'h8000_0000;
        end else begin
            r.hit   = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // saturating signed 32-bit add
    function automatic sat_t add_sat(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        logic signed [WIDE_W-1:0] s;
        s = WIDE_W'(a) + WIDE_W'(b);
        return sat32(s);
    endfunction

endpackage

`default_nettype wire

@@ sv/rigid_body_force_integrator.sv @@
// explicit euler velocity integrator for one 2d rigid body, signed q16.16
// depends on rbfi_pkg
`default_nettype none

// One body's linear velocity (x, y), angular velocity and force/torque
// accumulators, all signed Q16.16. Each input item is an operation: add force,
// add torque, add linear impulse (scaled by inverse mass), add angular impulse,
// time step, or clear the accumulators. Every item returns exactly one result
// item with the velocities after it and a flag that is set if any value was
// clamped to the signed 32-bit range. A time step does v += (F*inverse_mass)*dt,
// then v *= (1 - damping*dt), then clears the accumulators. Products floor
// after the 16-bit shift. All products go through one 33x33 signed multiplier
// whose output is registered, driven by a small sequencer, so one item is
// worked on at a time and s_ready is high only while the sequencer is idle.
// Force, torque, clear, unused codes and a step that does nothing use no
// product; a linear impulse works both linear lanes, an angular impulse one
// lane, and a time step all three (two with fixed rotation). Each product is
// a multiply into the product register, then a shift and clamp, and the
// steps of a time step are chained through that one multiplier.
// A finished result sits in an output register, so the next item is taken
// while it waits for m_ready. Configuration is written through cfg_valid /
// cfg_index / cfg_data (always ready) and must only change while idle.

module rigid_body_force_integrator (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_operation,
    input  wire logic signed [31:0] s_value_x,
    input  wire logic signed [31:0] s_value_y,
    input  wire logic [31:0] s_delta_time,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_velocity_x,
    output logic signed [31:0] m_velocity_y,
    output logic signed [31:0] m_angular_velocity,
    output logic             m_saturated
);

    // sequencer
    rbfi_pkg::state_t state_reg, state_next;
    rbfi_pkg::lane_t  lane_reg, lane_next;

    // configuration registers
    logic [31:0] inv_mass_reg, inv_mass_next;
    logic [31:0] lin_damp_reg, lin_damp_next;
    logic [31:0] ang_damp_reg, ang_damp_next;
    logic        dynamic_reg, dynamic_next;
    logic        fixed_rot_reg, fixed_rot_next;
    logic        awake_reg, awake_next;

    // body state
    logic signed [31:0] vel_x_reg, vel_x_next;
    logic signed [31:0] vel_y_reg, vel_y_next;
    logic signed [31:0] ang_vel_reg, ang_vel_next;
    logic signed [31:0] force_x_reg, force_x_next;
    logic signed [31:0] force_y_reg, force_y_next;
    logic signed [31:0] torque_reg, torque_next;

    // latched item
    rbfi_pkg::op_t      op_reg, op_next;
    logic signed [31:0] in_x_reg, in_x_next;
    logic signed [31:0] in_y_reg, in_y_next;
    logic [31:0]        dt_reg, dt_next;

    // working values
    logic signed [31:0] t_reg, t_next;      // running intermediate of one lane
    logic signed [31:0] kl_reg, kl_next;    // linear damping factor
    logic signed [31:0] ka_reg, ka_next;    // angular damping factor
    logic               sat_reg, sat_next;  // sticky clamp flag for this item

    // shared multiplier
    logic signed [rbfi_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [rbfi_pkg::PROD_W-1:0] p_reg, p_next;
    logic signed [rbfi_pkg::PROD_W-1:0] p_shift;
    logic signed [rbfi_pkg::WIDE_W-1:0] prod_q;
    rbfi_pkg::sat_t                     prod_sat, damp_sat, sum_sat;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] out_vx_reg, out_vx_next;
    logic signed [31:0] out_vy_reg, out_vy_next;
    logic signed [31:0] out_va_reg, out_va_next;
    logic               out_sat_reg, out_sat_next;

    // lane selection
    logic signed [31:0] v_sel, acc_sel, in_sel, k_sel;
    logic               rot_ok;
    logic               is_step;

    rbfi_pkg::sat_t fx_sat, fy_sat, tq_sat;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == rbfi_pkg::ST_IDLE);

    assign m_valid            = m_valid_reg;
    assign m_velocity_x       = out_vx_reg;
    assign m_velocity_y       = out_vy_reg;
    assign m_angular_velocity = out_va_reg;
    assign m_saturated        = out_sat_reg;

    assign rot_ok  = dynamic_reg && !fixed_rot_reg;
    assign is_step = (op_reg == rbfi_pkg::OP_TIME_STEP);

    always_comb begin
        case (lane_reg)
            rbfi_pkg::LANE_X: begin
                v_sel   = vel_x_reg;
                acc_sel = force_x_reg;
                in_sel  = in_x_reg;
                k_sel   = kl_reg;
            end
            rbfi_pkg::LANE_Y: begin
                v_sel   = vel_y_reg;
                acc_sel = force_y_reg;
                in_sel  = in_y_reg;
                k_sel   = kl_reg;
            end
            rbfi_pkg::LANE_A: begin
                v_sel   = ang_vel_reg;
                acc_sel = torque_reg;
                in_sel  = in_x_reg;
                k_sel   = ka_reg;
            end
            default: begin
                v_sel   = vel_x_reg;
                acc_sel = force_x_reg;
                in_sel  = in_x_reg;
                k_sel   = kl_reg;
            end
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            rbfi_pkg::ST_KL_MUL: begin
                mul_a = {1'b0, lin_damp_reg};
                mul_b = {1'b0, dt_reg};
            end
            rbfi_pkg::ST_KA_MUL: begin
                mul_a = {1'b0, ang_damp_reg};
                mul_b = {1'b0, dt_reg};
            end
            rbfi_pkg::ST_T_MUL: begin
                mul_a = is_step ? {acc_sel[31], acc_sel} : {in_sel[31], in_sel};
                mul_b = {1'b0, inv_mass_reg};
            end
            rbfi_pkg::ST_U_MUL: begin
                mul_a = {t_reg[31], t_reg};
                mul_b = {1'b0, dt_reg};
            end
            rbfi_pkg::ST_V_MUL: begin
                mul_a = {t_reg[31], t_reg};
                mul_b = {k_sel[31], k_sel};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p_next  = mul_a * mul_b;
    // arithmetic shift of the registered product floors toward minus infinity
    assign p_shift = p_reg >>> rbfi_pkg::FRAC_W;
    assign prod_q  = $signed(p_shift[rbfi_pkg::WIDE_W-1:0]);

    assign prod_sat = rbfi_pkg::sat32(prod_q);
    assign damp_sat = rbfi_pkg::sat32(rbfi_pkg::Q_ONE - prod_q);
    assign sum_sat  = rbfi_pkg::add_sat(v_sel, t_reg);

    // accumulator adds for the force and torque operations
    assign fx_sat = rbfi_pkg::add_sat(force_x_reg, in_x_reg);
    assign fy_sat = rbfi_pkg::add_sat(force_y_reg, in_y_reg);
    assign tq_sat = rbfi_pkg::add_sat(torque_reg, in_x_reg);

    // next state and datapath updates
    always_comb begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        inv_mass_next  = inv_mass_reg;
        lin_damp_next  = lin_damp_reg;
        ang_damp_next  = ang_damp_reg;
        dynamic_next   = dynamic_reg;
        fixed_rot_next = fixed_rot_reg;
        awake_next     = awake_reg;
        vel_x_next     = vel_x_reg;
        vel_y_next     = vel_y_reg;
        ang_vel_next   = ang_vel_reg;
        force_x_next   = force_x_reg;
        force_y_next   = force_y_reg;
        torque_next    = torque_reg;
        op_next        = op_reg;
        in_x_next      = in_x_reg;
        in_y_next      = in_y_reg;
        dt_next        = dt_reg;
        t_next         = t_reg;
        kl_next        = kl_reg;
        ka_next        = ka_reg;
        sat_next       = sat_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_vx_next    = out_vx_reg;
        out_vy_next    = out_vy_reg;
        out_va_next    = out_va_reg;
        out_sat_next   = out_sat_reg;

        // configuration writes; the user must write only while idle, the block does not enforce it
        if (cfg_valid) begin
            case (rbfi_pkg::cfg_idx_t'(cfg_index))
                rbfi_pkg::CFG_INVERSE_MASS:    inv_mass_next  = cfg_data;
                rbfi_pkg::CFG_LINEAR_DAMPING:  lin_damp_next  = cfg_data;
                rbfi_pkg::CFG_ANGULAR_DAMPING: ang_damp_next  = cfg_data;
                rbfi_pkg::CFG_IS_DYNAMIC:      dynamic_next   = cfg_data[0];
                rbfi_pkg::CFG_FIXED_ROTATION:  fixed_rot_next = cfg_data[0];
                rbfi_pkg::CFG_AWAKE:           awake_next     = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            rbfi_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next    = rbfi_pkg::op_t'(s_operation);
                    in_x_next  = s_value_x;
                    in_y_next  = s_value_y;
                    dt_next    = s_delta_time;
                    sat_next   = 1'b0;
                    state_next = rbfi_pkg::ST_DECODE;
                end
            end

            rbfi_pkg::ST_DECODE: begin
                state_next = rbfi_pkg::ST_OUT;
                case (op_reg)
                    rbfi_pkg::OP_FORCE: begin
                        if (dynamic_reg) begin
                            force_x_next = fx_sat.value;
                            force_y_next = fy_sat.value;
                            sat_next     = fx_sat.hit || fy_sat.hit;
                        end
                    end
                    rbfi_pkg::OP_TORQUE: begin
                        if (rot_ok) begin
                            torque_next = tq_sat.value;
                            sat_next    = tq_sat.hit;
                        end
                    end
                    rbfi_pkg::OP_IMPULSE: begin
                        if (dynamic_reg) begin
                            lane_next  = rbfi_pkg::LANE_X;
                            state_next = rbfi_pkg::ST_T_MUL;
                        end
                    end
                    rbfi_pkg::OP_ANG_IMPULSE: begin
                        if (rot_ok) begin
                            lane_next  = rbfi_pkg::LANE_A;
                            state_next = rbfi_pkg::ST_T_MUL;
                        end
                    end
                    rbfi_pkg::OP_TIME_STEP: begin
                        if (dynamic_reg && awake_reg) begin
                            state_next = rbfi_pkg::ST_KL_MUL;
                        end
                    end
                    rbfi_pkg::OP_CLEAR: begin
                        force_x_next = '0;
                        force_y_next = '0;
                        torque_next  = '0;
                    end
                    default: ;
                endcase
            end

            rbfi_pkg::ST_KL_MUL: state_next = rbfi_pkg::ST_KL_WB;

            rbfi_pkg::ST_KL_WB: begin
                kl_next   = damp_sat.value;
                sat_next  = sat_reg || damp_sat.hit;
                lane_next = rbfi_pkg::LANE_X;
                state_next = fixed_rot_reg ? rbfi_pkg::ST_T_MUL : rbfi_pkg::ST_KA_MUL;
            end

            rbfi_pkg::ST_KA_MUL: state_next = rbfi_pkg::ST_KA_WB;

            rbfi_pkg::ST_KA_WB: begin
                ka_next    = damp_sat.value;
                sat_next   = sat_reg || damp_sat.hit;
                lane_next  = rbfi_pkg::LANE_X;
                state_next = rbfi_pkg::ST_T_MUL;
            end

            // t = clamp(floor(value * inverse_mass))
            rbfi_pkg::ST_T_MUL: state_next = rbfi_pkg::ST_T_WB;

            rbfi_pkg::ST_T_WB: begin
                t_next     = prod_sat.value;
                sat_next   = sat_reg || prod_sat.hit;
                state_next = is_step ? rbfi_pkg::ST_U_MUL : rbfi_pkg::ST_SUM;
            end

            // u = clamp(floor(t * dt))
            rbfi_pkg::ST_U_MUL: state_next = rbfi_pkg::ST_U_WB;

            rbfi_pkg::ST_U_WB: begin
                t_next     = prod_sat.value;
                sat_next   = sat_reg || prod_sat.hit;
                state_next = rbfi_pkg::ST_SUM;
            end

            // w = clamp(v + t); an impulse writes it back, a step goes on to damping
            rbfi_pkg::ST_SUM: begin
                sat_next = sat_reg || sum_sat.hit;
                if (is_step) begin
                    t_next     = sum_sat.value;
                    state_next = rbfi_pkg::ST_V_MUL;
                end else begin
                    case (lane_reg)
                        rbfi_pkg::LANE_X: vel_x_next   = sum_sat.value;
                        rbfi_pkg::LANE_Y: vel_y_next   = sum_sat.value;
                        rbfi_pkg::LANE_A: ang_vel_next = sum_sat.value;
                        default: ;
                    endcase
                    if (lane_reg == rbfi_pkg::LANE_X) begin
                        lane_next  = rbfi_pkg::LANE_Y;
                        state_next = rbfi_pkg::ST_T_MUL;
                    end else begin
                        state_next = rbfi_pkg::ST_OUT;
                    end
                end
            end

            // v = clamp(floor(w * k))
            rbfi_pkg::ST_V_MUL: state_next = rbfi_pkg::ST_V_WB;

            rbfi_pkg::ST_V_WB: begin
                sat_next = sat_reg || prod_sat.hit;
                case (lane_reg)
                    rbfi_pkg::LANE_X: vel_x_next   = prod_sat.value;
                    rbfi_pkg::LANE_Y: vel_y_next   = prod_sat.value;
                    rbfi_pkg::LANE_A: ang_vel_next = prod_sat.value;
                    default: ;
                endcase
                if (lane_reg == rbfi_pkg::LANE_X) begin
                    lane_next  = rbfi_pkg::LANE_Y;
                    state_next = rbfi_pkg::ST_T_MUL;
                end else if (lane_reg == rbfi_pkg::LANE_Y && !fixed_rot_reg) begin
                    lane_next  = rbfi_pkg::LANE_A;
                    state_next = rbfi_pkg::ST_T_MUL;
                end else begin
                    // step finished: accumulators are consumed
                    force_x_next = '0;
                    force_y_next = '0;
                    torque_next  = '0;
                    state_next   = rbfi_pkg::ST_OUT;
                end
            end

            rbfi_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_vx_next  = vel_x_reg;
                    out_vy_next  = vel_y_reg;
                    out_va_next  = ang_vel_reg;
                    out_sat_next = sat_reg;
                    state_next   = rbfi_pkg::ST_IDLE;
                end
            end

            default: state_next = rbfi_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbfi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control, configuration and body state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg      <= rbfi_pkg::LANE_X;
            inv_mass_reg  <= 32'h0001_0000;
            lin_damp_reg  <= '0;
            ang_damp_reg  <= '0;
            dynamic_reg   <= 1'b1;
            fixed_rot_reg <= 1'b0;
            awake_reg     <= 1'b1;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            ang_vel_reg   <= '0;
            force_x_reg   <= '0;
            force_y_reg   <= '0;
            torque_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            lane_reg      <= lane_next;
            inv_mass_reg  <= inv_mass_next;
            lin_damp_reg  <= lin_damp_next;
            ang_damp_reg  <= ang_damp_next;
            dynamic_reg   <= dynamic_next;
            fixed_rot_reg <= fixed_rot_next;
            awake_reg     <= awake_next;
            vel_x_reg     <= vel_x_next;
            vel_y_reg     <= vel_y_next;
            ang_vel_reg   <= ang_vel_next;
            force_x_reg   <= force_x_next;
            force_y_reg   <= force_y_next;
            torque_reg    <= torque_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        in_x_reg    <= in_x_next;
        in_y_reg    <= in_y_next;
        dt_reg      <= dt_next;
        t_reg       <= t_next;
        kl_reg      <= kl_next;
        ka_reg      <= ka_next;
        sat_reg     <= sat_next;
        p_reg       <= p_next;
        out_vx_reg  <= out_vx_next;
        out_vy_reg  <= out_vy_next;
        out_va_reg  <= out_va_next;
        out_sat_reg <= out_sat_next;
    end

endmodule

`default_nettype wire

@@ test/rigid_body_force_integrator_tb.sv @@
// self-checking bench for rigid_body_force_integrator: random and directed items,
// predicted velocities compared per result item; depends on rbfi_pkg and the block
`timescale 1ns / 1ps

module rigid_body_force_integrator_tb;

    // codes the package leaves unnamed, the block must treat them as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [31:0] TOP_S32  = 32'h7FFF_FFFF;
    localparam logic [31:0] BOT_S32  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam longint LIM_HI = 64'sd2147483647;
    localparam longint LIM_LO = -64'sd2147483648;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        dt;
    } body_cmd_t;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] av;
        logic               sat;
    } body_vel_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_operation  = '0;
    logic signed [31:0] s_value_x    = '0;
    logic signed [31:0] s_value_y    = '0;
    logic [31:0]        s_delta_time = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_velocity_x;
    logic signed [31:0] m_velocity_y;
    logic signed [31:0] m_angular_velocity;
    logic               m_saturated;

    rigid_body_force_integrator dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_value_x          (s_value_x),
        .s_value_y          (s_value_y),
        .s_delta_time       (s_delta_time),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_velocity_x       (m_velocity_x),
        .m_velocity_y       (m_velocity_y),
        .m_angular_velocity (m_angular_velocity),
        .m_saturated        (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // body shadow: registers and state as the block should hold them
    // ------------------------------------------------------------------
    logic [31:0]        inv_mass_q  = ONE_Q16;
    logic [31:0]        lin_damp_q  = '0;
    logic [31:0]        ang_damp_q  = '0;
    logic               dynamic_on  = 1'b1;
    logic               rot_locked  = 1'b0;
    logic               body_awake  = 1'b1;
    logic signed [31:0] lin_vel_x   = '0;
    logic signed [31:0] lin_vel_y   = '0;
    logic signed [31:0] spin_vel    = '0;
    logic signed [31:0] force_acc_x = '0;
    logic signed [31:0] force_acc_y = '0;
    logic signed [31:0] torque_acc  = '0;
    logic               clip_seen   = 1'b0;

    // clamp to signed 32 bits, remembering any clamp for this item
    function automatic logic signed [31:0] clip32(input longint v);
        if (v > LIM_HI) begin
            clip_seen = 1'b1;
            return TOP_S32;
        end
        if (v < LIM_LO) begin
            clip_seen = 1'b1;
            return BOT_S32;
        end
        return v[31:0];
    endfunction

    // exact product, floor after dropping the fraction bits
    function automatic longint mul_floor(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic logic signed [31:0] scale_by_mass(input logic signed [31:0] a);
        return clip32(mul_floor(longint'(a), longint'(inv_mass_q)));
    endfunction

    // 1.0 - rate*dt, may go negative
    function automatic logic signed [31:0] damping_gain(input logic [31:0] rate,
                                                        input logic [31:0] dt);
        longint unsigned p;
        p = 64'(rate) * 64'(dt);
        return clip32(longint'(ONE_Q16) - longint'(p >> 16));
    endfunction

    function automatic logic signed [31:0] euler_lane(input logic signed [31:0] v,
                                                      input logic signed [31:0] acc,
                                                      input logic [31:0] dt,
                                                      input logic signed [31:0] k);
        logic signed [31:0] t, u, w;
        t = scale_by_mass(acc);
        u = clip32(mul_floor(longint'(t), longint'(dt)));
        w = clip32(longint'(v) + longint'(u));
        return clip32(mul_floor(longint'(w), longint'(k)));
    endfunction

    // advance the shadow body by one item and return the velocities it reports
    function automatic body_vel_t advance_body(input body_cmd_t c);
        logic               spin_ok;
        logic signed [31:0] kl, ka, dx, dy;
        body_vel_t          r;
        clip_seen = 1'b0;
        spin_ok   = dynamic_on && !rot_locked;
        case (c.op)
            rbfi_pkg::OP_FORCE: begin
                if (dynamic_on) begin
                    force_acc_x = clip32(longint'(force_acc_x) + longint'(c.vx));
                    force_acc_y = clip32(longint'(force_acc_y) + longint'(c.vy));
                end
            end
            rbfi_pkg::OP_TORQUE: begin
                if (spin_ok) torque_acc = clip32(longint'(torque_acc) + longint'(c.vx));
            end
            rbfi_pkg::OP_IMPULSE: begin
                if (dynamic_on) begin
                    dx = scale_by_mass(c.vx);
                    dy = scale_by_mass(c.vy);
                    lin_vel_x = clip32(longint'(lin_vel_x) + longint'(dx));
                    lin_vel_y = clip32(longint'(lin_vel_y) + longint'(dy));
                end
            end
            rbfi_pkg::OP_ANG_IMPULSE: begin
                if (spin_ok)
                    spin_vel = clip32(longint'(spin_vel) + longint'(scale_by_mass(c.vx)));
            end
            rbfi_pkg::OP_TIME_STEP: begin
                // static or sleeping bodies keep velocities and accumulators
                if (dynamic_on && body_awake) begin
                    kl = damping_gain(lin_damp_q, c.dt);
                    lin_vel_x = euler_lane(lin_vel_x, force_acc_x, c.dt, kl);
                    lin_vel_y = euler_lane(lin_vel_y, force_acc_y, c.dt, kl);
                    if (!rot_locked) begin
                        ka = damping_gain(ang_damp_q, c.dt);
                        spin_vel = euler_lane(spin_vel, torque_acc, c.dt, ka);
                    end
                    force_acc_x = '0;
                    force_acc_y = '0;
                    torque_acc  = '0;
                end
            end
            rbfi_pkg::OP_CLEAR: begin
                force_acc_x = '0;
                force_acc_y = '0;
                torque_acc  = '0;
            end
            default: ;
        endcase
        r.vx  = lin_vel_x;
        r.vy  = lin_vel_y;
        r.av  = spin_vel;
        r.sat = clip_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // queues, pacing knobs, handshake flags
    // ------------------------------------------------------------------
    body_cmd_t cmd_queue[$];
    body_vel_t vel_due[$];
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    int        send_gap_max = 9;
    int        recv_gap_max = 9;
    int        send_wait    = 0;
    int        recv_wait    = 0;
    int        hold_tokens  = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;
    logic      s_took   = 1'b0;
    logic      m_took   = 1'b0;
    logic      cfg_took = 1'b0;

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // monitor: handshakes sampled at the rising edge, predictor runs on acceptance
    always @(posedge aclk) begin
        body_vel_t want;
        if (!aresetn) begin
            s_took       <= 1'b0;
            m_took       <= 1'b0;
            cfg_took     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            s_took   <= s_valid && s_ready;
            m_took   <= m_valid && m_ready;
            cfg_took <= cfg_valid && cfg_ready;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rbfi_pkg::CFG_INVERSE_MASS:    inv_mass_q = cfg_data;
                    rbfi_pkg::CFG_LINEAR_DAMPING:  lin_damp_q = cfg_data;
                    rbfi_pkg::CFG_ANGULAR_DAMPING: ang_damp_q = cfg_data;
                    rbfi_pkg::CFG_IS_DYNAMIC:      dynamic_on = cfg_data[0];
                    rbfi_pkg::CFG_FIXED_ROTATION:  rot_locked = cfg_data[0];
                    rbfi_pkg::CFG_AWAKE:           body_awake = cfg_data[0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                vel_due.push_back(advance_body({s_operation, s_value_x, s_value_y,
                                                s_delta_time}));

            if (m_valid && m_ready) begin
                if (vel_due.size() == 0) begin
                    $display("%0t ns: result item with nothing expected, got %h %h %h %b",
                             $time, m_velocity_x, m_velocity_y, m_angular_velocity,
                             m_saturated);
                    mismatches++;
                end else begin
                    want = vel_due.pop_front();
                    check_field("velocity_x", want.vx, m_velocity_x);
                    check_field("velocity_y", want.vy, m_velocity_y);
                    check_field("angular_velocity", want.av, m_angular_velocity);
                    check_field("saturated", 32'(want.sat), 32'(m_saturated));
                end
            end

            // watchdog: any accepted item on any channel counts as progress
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // driver: presents queued items on the falling edge, random gap per item
    always @(negedge aclk) begin
        body_cmd_t c;
        if (s_took) send_wait = $urandom_range(0, send_gap_max);
        if (!s_valid || s_took) begin
            if (send_wait != 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                c = cmd_queue.pop_front();
                s_operation  <= c.op;
                s_value_x    <= c.vx;
                s_value_y    <= c.vy;
                s_delta_time <= c.dt;
                s_valid      <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall per result item, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen != hold_tokens) begin
            hold_seen = hold_tokens;
            hold_left = HOLD_CYCLES;
        end
        if (m_took) recv_wait = $urandom_range(0, recv_gap_max);
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (recv_wait != 0) begin
            recv_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(input logic [2:0] op, input logic [31:0] x, input logic [31:0] y,
                        input logic [31:0] dt);
        cmd_queue.push_back({op, x, y, dt});
    endtask

    // sender holds back until every queued item is taken and answered
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || s_valid || vel_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input rbfi_pkg::cfg_idx_t idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_body(input logic [31:0] im, input logic [31:0] ld,
                            input logic [31:0] ad, input logic dyn, input logic fix,
                            input logic awk);
        write_reg(rbfi_pkg::CFG_INVERSE_MASS, im);
        write_reg(rbfi_pkg::CFG_LINEAR_DAMPING, ld);
        write_reg(rbfi_pkg::CFG_ANGULAR_DAMPING, ad);
        write_reg(rbfi_pkg::CFG_IS_DYNAMIC, {31'b0, dyn});
        write_reg(rbfi_pkg::CFG_FIXED_ROTATION, {31'b0, fix});
        write_reg(rbfi_pkg::CFG_AWAKE, {31'b0, awk});
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h000A_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            6, 7:             v = $urandom;
            8: begin
                case ($urandom_range(0, 3))
                    0:       v = TOP_S32;
                    1:       v = BOT_S32;
                    2:       v = '0;
                    default: v = ALL_ONES;
                endcase
            end
            default:          v = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_dt();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 6554);      // frame-sized steps
            6, 7:             return $urandom_range(0, 32'h0004_0000);
            8:                return $urandom;
            default:          return $urandom_range(0, 1) ? ALL_ONES : 32'h0;
        endcase
    endfunction

    function automatic body_cmd_t random_cmd();
        body_cmd_t   c;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)       c.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        else if (r < 28) c.op = rbfi_pkg::OP_FORCE;
        else if (r < 40) c.op = rbfi_pkg::OP_TORQUE;
        else if (r < 55) c.op = rbfi_pkg::OP_IMPULSE;
        else if (r < 65) c.op = rbfi_pkg::OP_ANG_IMPULSE;
        else if (r < 92) c.op = rbfi_pkg::OP_TIME_STEP;
        else             c.op = rbfi_pkg::OP_CLEAR;
        c.vx = pick_value();
        c.vy = pick_value();
        c.dt = pick_dt();
        return c;
    endfunction

    task automatic random_body();
        logic [31:0] im;
        case ($urandom_range(0, 4))
            0:       im = '0;
            1:       im = ONE_Q16;
            2:       im = ALL_ONES;
            3:       im = $urandom_range(0, 32'h0004_0000);
            default: im = $urandom;
        endcase
        set_body(im, pick_rate(), pick_rate(), $urandom_range(0, 9) != 0,
                 $urandom_range(0, 3) == 0, $urandom_range(0, 7) != 0);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset body: accumulators and velocities driven into both rails
        send(rbfi_pkg::OP_FORCE, TOP_S32, BOT_S32, 32'h0);
        send(rbfi_pkg::OP_FORCE, TOP_S32, BOT_S32, ALL_ONES);
        send(rbfi_pkg::OP_TORQUE, TOP_S32, 32'h1234_5678, 32'h0);
        send(rbfi_pkg::OP_TORQUE, TOP_S32, 32'h0, 32'h0);
        send(rbfi_pkg::OP_TIME_STEP, 32'h0, 32'h0, ONE_Q16);
        send(rbfi_pkg::OP_IMPULSE, TOP_S32, BOT_S32, 32'h0);
        send(rbfi_pkg::OP_IMPULSE, TOP_S32, BOT_S32, 32'h0);
        send(rbfi_pkg::OP_ANG_IMPULSE, BOT_S32, TOP_S32, 32'h0);
        send(rbfi_pkg::OP_FORCE, ONE_Q16, ALL_ONES, 32'h0);
        send(rbfi_pkg::OP_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES);
        send(OP_SPARE_6, TOP_S32, TOP_S32, ALL_ONES);
        send(OP_SPARE_7, BOT_S32, BOT_S32, ALL_ONES);
        send(rbfi_pkg::OP_TIME_STEP, 32'h0, 32'h0, 32'h0);
        send(rbfi_pkg::OP_TIME_STEP, 32'h0, 32'h0, ALL_ONES);
        wait_idle();

        // maximum inverse mass and damping, damping gain goes negative
        set_body(ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b0, 1'b1);
        send(rbfi_pkg::OP_FORCE, ONE_Q16, ALL_ONES, 32'h0);
        send(rbfi_pkg::OP_TORQUE, BOT_S32, 32'h0, 32'h0);
        send(rbfi_pkg::OP_TIME_STEP, 32'h0, 32'h0, 32'h0000_0100);
        wait_idle();

        // static body: only clear has an effect
        set_body(ONE_Q16, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1);
        send(rbfi_pkg::OP_FORCE, ONE_Q16, ONE_Q16, 32'h0);
        send(rbfi_pkg::OP_IMPULSE, ONE_Q16, ONE_Q16, 32'h0);
        send(rbfi_pkg::OP_TIME_STEP, 32'h0, 32'h0, ONE_Q16);
        send(rbfi_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
        wait_idle();

        // asleep with locked rotation and zero inverse mass
        set_body(32'h0, ONE_Q16, ONE_Q16, 1'b1, 1'b1, 1'b0);
        send(rbfi_pkg::OP_TORQUE, ONE_Q16, 32'h0, 32'h0);
        send(rbfi_pkg::OP_ANG_IMPULSE, TOP_S32, 32'h0, 32'h0);
        send(rbfi_pkg::OP_IMPULSE, TOP_S32, BOT_S32, 32'h0);
        send(rbfi_pkg::OP_TIME_STEP, 32'h0, 32'h0, ONE_Q16);
        wait_idle();

        // random phases, each under its own body settings
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            if (ph == 1)      set_body(ALL_ONES, ALL_ONES, 32'h0, 1'b1, 1'b0, 1'b1);
            else if (ph == 2) set_body(32'h0, 32'h0, ALL_ONES, 1'b1, 1'b0, 1'b1);
            else              random_body();
            send_gap_max = (ph % 3 == 0) ? 0 : 9;
            recv_gap_max = (ph % 3 == 1) ? 0 : 9;
            if (ph == 4) begin
                // receiver holds off while the sender keeps offering items
                send_gap_max = 0;
                hold_tokens++;
            end
            for (int i = 0; i < 50; i++) begin
                if (i == 25 && ph % 2 == 1) wait_idle();
                cmd_queue.push_back(random_cmd());
            end
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
